// ===== rtl/i2c_eeprom_page_write_master_defines.svh =====
// Assertion macros for the I2C EEPROM page-write master.
// Depends on nothing; included by the top level for its property checks.
`ifndef I2C_EEPROM_PAGE_WRITE_MASTER_DEFINES_SVH
`define I2C_EEPROM_PAGE_WRITE_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IEPW_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("iepw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IEPW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("iepw assertion failed");

`endif

// ===== rtl/iepw_pkg.sv =====
// Shared types and constants of the I2C EEPROM page-write master.
// Depends on nothing; imported by the shifter and the top level.
package iepw_pkg;

    localparam int AddrBits    = 8;
    localparam int ByteBits    = 8;
    localparam int DevBits     = 7;
    localparam int PageCfgBits = 4;
    localparam int BitCntBits  = 4;

    localparam logic [BitCntBits-1:0] AckSlotCount = BitCntBits'(ByteBits);
    localparam logic [PageCfgBits-1:0] PageBitsReset = 4'd4;
    localparam logic [PageCfgBits-1:0] PageBitsMax   = PageCfgBits'(AddrBits);

    // Symbol kinds on the result channel.
    localparam logic [2:0] SYM_START = 3'd0;
    localparam logic [2:0] SYM_BIT   = 3'd1;
    localparam logic [2:0] SYM_ACK   = 3'd2;
    localparam logic [2:0] SYM_STOP  = 3'd3;
    localparam logic [2:0] SYM_WAIT  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_STOP,
        ST_PRE_WAIT,
        ST_START,
        ST_DEV,
        ST_ADDR,
        ST_DATA,
        ST_STOP,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic                load;
        logic [ByteBits-1:0] value;
        logic                step;
    } shift_ctrl_t;

    typedef struct packed {
        logic sda;
        logic ack_slot;
    } shift_stat_t;

endpackage

// ===== rtl/iepw_shifter.sv =====
// Byte serializer shared by the device, address and data bytes.
// Depends on iepw_pkg for the control and status structs.
module iepw_shifter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iepw_pkg::shift_ctrl_t ctrl,
    output iepw_pkg::shift_stat_t stat
);
    import iepw_pkg::*;

    logic [ByteBits-1:0]   shift_reg;
    logic [ByteBits-1:0]   shift_next;
    logic [BitCntBits-1:0] count_reg;
    logic [BitCntBits-1:0] count_next;

    always_comb begin
        shift_next = shift_reg;
        count_next = count_reg;
        if (ctrl.load) begin
            shift_next = ctrl.value;
            count_next = '0;
        end else if (ctrl.step) begin
            shift_next = {shift_reg[ByteBits-2:0], 1'b0};
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign stat.sda      = shift_reg[ByteBits-1];
    assign stat.ack_slot = (count_reg == AckSlotCount);

endmodule

// ===== rtl/i2c_eeprom_page_write_master.sv =====
// Top level of the I2C EEPROM page-write master: sequencer and output register.
// Depends on iepw_pkg, iepw_shifter and i2c_eeprom_page_write_master_defines.svh.
//
// Usage:
//   The input channel (s_*) takes one data byte per beat, with the device
//   address and start address (used when s_first_of_write is set) and the
//   first/last marks. The result channel (m_*) delivers one bus symbol per
//   beat: start, data bit, released ack slot, stop or write-cycle wait.
//   m_last_symbol marks the final symbol caused by an input beat.
//   One input beat expands into 9 to 32 symbols. A shared byte shifter
//   serializes the device, address and data bytes in turn, one bit per
//   cycle, under a small sequencer, so one symbol leaves per cycle unless
//   m_ready stalls. All symbols of an item are issued before the next beat
//   is taken; the first is issued from the state entered on the accept and
//   then registered. s_ready is high only while the sequencer is idle.
//   A stall on m_ready holds the output register and freezes the sequencer;
//   nothing is lost. Reset clears the bus state (idle, address and device
//   zero) and sets page_bits to 4. cfg_we writes page_bits at once; write
//   it only while the block is idle.
module i2c_eeprom_page_write_master (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    // input beats
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [6:0] s_device_address,
    input  logic [7:0] s_start_address,
    input  logic [7:0] s_data_byte,
    input  logic       s_first_of_write,
    input  logic       s_last_of_write,
    // result beats
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_symbol_kind,
    output logic       m_sda_level,
    output logic       m_last_symbol
);
    import iepw_pkg::*;
    `include "i2c_eeprom_page_write_master_defines.svh"

    state_t state_reg, state_next;

    logic [PageCfgBits-1:0] page_bits_reg, page_bits_next;
    logic [AddrBits-1:0]    addr_reg, addr_next;
    logic [DevBits-1:0]     dev_reg, dev_next;
    logic                   in_tx_reg, in_tx_next;
    logic [ByteBits-1:0]    data_reg, data_next;
    logic                   last_reg, last_next;

    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_kind_reg, m_kind_next;
    logic       m_sda_reg, m_sda_next;
    logic       m_last_reg, m_last_next;

    shift_ctrl_t sh_ctrl;
    shift_stat_t sh_stat;

    logic                   s_accept;
    logic                   slot_free;
    logic                   emit;
    logic [PageCfgBits-1:0] page_bits_clamped;
    logic [AddrBits-1:0]    page_mask;
    logic [AddrBits-1:0]    addr_plus;
    logic                   close_now;

    iepw_shifter u_shifter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sh_ctrl),
        .stat    (sh_stat)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    // Output slot can take a new symbol when empty or being drained.
    assign slot_free = !m_valid_reg || m_ready;

    // Page sizes beyond the address width leave the wrap as the only boundary.
    assign page_bits_clamped = (page_bits_reg > PageBitsMax) ? PageBitsMax : page_bits_reg;
    assign page_mask = ~({AddrBits{1'b1}} << page_bits_clamped);
    assign addr_plus = addr_reg + 1'b1;
    assign close_now = last_reg || ((addr_plus & page_mask) == '0);

    always_comb begin
        state_next     = state_reg;
        page_bits_next = page_bits_reg;
        addr_next      = addr_reg;
        dev_next       = dev_reg;
        in_tx_next     = in_tx_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        m_kind_next    = m_kind_reg;
        m_sda_next     = m_sda_reg;
        m_last_next    = m_last_reg;
        sh_ctrl.load   = 1'b0;
        sh_ctrl.value  = data_reg;
        sh_ctrl.step   = 1'b0;

        if (cfg_we) begin
            page_bits_next = cfg_wdata;
        end

        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_accept) begin
                    data_next = s_data_byte;
                    last_next = s_last_of_write;
                    if (s_first_of_write) begin
                        dev_next  = s_device_address;
                        addr_next = s_start_address;
                    end
                    if (s_first_of_write && in_tx_reg) begin
                        // Close the open write before opening the new one.
                        state_next = ST_PRE_STOP;
                    end else if (!in_tx_reg) begin
                        state_next = ST_START;
                    end else begin
                        sh_ctrl.load  = 1'b1;
                        sh_ctrl.value = s_data_byte;
                        state_next    = ST_DATA;
                    end
                end
            end
            ST_PRE_STOP: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    m_kind_next = SYM_STOP;
                    m_sda_next  = 1'b0;
                    m_last_next = 1'b0;
                    state_next  = ST_PRE_WAIT;
                end
            end
            ST_PRE_WAIT: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    m_kind_next = SYM_WAIT;
                    m_sda_next  = 1'b0;
                    m_last_next = 1'b0;
                    in_tx_next  = 1'b0;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                if (slot_free) begin
                    emit          = 1'b1;
                    m_kind_next   = SYM_START;
                    m_sda_next    = 1'b0;
                    m_last_next   = 1'b0;
                    in_tx_next    = 1'b1;
                    // Device byte carries write bit 0.
                    sh_ctrl.load  = 1'b1;
                    sh_ctrl.value = {dev_reg, 1'b0};
                    state_next    = ST_DEV;
                end
            end
            ST_DEV, ST_ADDR, ST_DATA: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    m_last_next = 1'b0;
                    if (!sh_stat.ack_slot) begin
                        m_kind_next  = SYM_BIT;
                        m_sda_next   = sh_stat.sda;
                        sh_ctrl.step = 1'b1;
                    end else begin
                        m_kind_next = SYM_ACK;
                        m_sda_next  = 1'b1;
                        if (state_reg == ST_DEV) begin
                            sh_ctrl.load  = 1'b1;
                            sh_ctrl.value = addr_reg;
                            state_next    = ST_ADDR;
                        end else if (state_reg == ST_ADDR) begin
                            sh_ctrl.load  = 1'b1;
                            sh_ctrl.value = data_reg;
                            state_next    = ST_DATA;
                        end else begin
                            // Advance the address; close on last byte or page boundary.
                            addr_next   = addr_plus;
                            m_last_next = !close_now;
                            state_next  = close_now ? ST_STOP : ST_IDLE;
                        end
                    end
                end
            end
            ST_STOP: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    m_kind_next = SYM_STOP;
                    m_sda_next  = 1'b0;
                    m_last_next = 1'b0;
                    state_next  = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    m_kind_next = SYM_WAIT;
                    m_sda_next  = 1'b0;
                    m_last_next = 1'b1;
                    in_tx_next  = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            page_bits_reg <= PageBitsReset;
            addr_reg      <= '0;
            dev_reg       <= '0;
            in_tx_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            page_bits_reg <= page_bits_next;
            addr_reg      <= addr_next;
            dev_reg       <= dev_next;
            in_tx_reg     <= in_tx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        last_reg   <= last_next;
        m_kind_reg <= m_kind_next;
        m_sda_reg  <= m_sda_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_symbol_kind = m_kind_reg;
    assign m_sda_level   = m_sda_reg;
    assign m_last_symbol = m_last_reg;

    // Property checks.
    `IEPW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_ready)
    `IEPW_ASSERT_IMPL(a_last_kind, aclk, aresetn, m_valid && m_last_symbol,
        (m_symbol_kind == SYM_WAIT) || (m_symbol_kind == SYM_ACK))
    `IEPW_ASSERT_IMPL(a_sda_kind, aclk, aresetn, m_valid && m_sda_level,
        (m_symbol_kind == SYM_BIT) || (m_symbol_kind == SYM_ACK))

endmodule
